@@ src/assert_macros.svh @@
// Assertion helpers: clock clk, synchronous reset rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ src/ltilt_pkg.sv @@
package ltilt_pkg;

  localparam int SQRT_CELLS = 32;
  localparam int DIV_CELLS  = 32;
  localparam int ADDR_W     = 3;

  localparam logic [30:0]        COS_RESET = 31'd1073734951;
  localparam logic signed [31:0] SIN_RESET = 32'sd3841760;

  localparam logic signed [66:0] HALF_Q30 = 67'sd536870912;
  localparam logic signed [36:0] SAT_MAX  = 37'sd2147483647;
  localparam logic signed [36:0] SAT_MIN  = -37'sd2147483648;

  typedef enum logic {
    REG_COSINE = 1'b0,
    REG_SINE   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sx;
    logic               sy;
    logic [62:0]        mx;
    logic [62:0]        my;
    logic [63:0]        n;
    logic [33:0]        rem;
    logic [31:0]        root;
  } sqrt_stage_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sx;
    logic               sy;
    logic [31:0]        r;
    logic [31:0]        px;
    logic [31:0]        lx;
    logic [31:0]        py;
    logic [31:0]        ly;
  } div_stage_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               on_axis;
  } result_t;

endpackage

@@ src/lidar_point_elevation_tilt_core.sv @@
// channel   | handshake                   | payload
// point     | point_valid / point_stall   | x_in, y_in, z_in
// result    | result_valid / result_stall | x_out, y_out, z_out, on_axis
// config    | psel/penable/pwrite/pready  | paddr, pwdata, prdata
// One point per cycle while point_stall is low. Path: input and head registers,
// 32 square-root cells then 32 divider cells (one bit each), stages C and D, result.
// Result register plus one skid entry; point_stall rises only when both hold.
// Synchronous reset clears valid flags and loads the tilt registers.
module lidar_point_elevation_tilt_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          point_valid,
  output logic                          point_stall,
  input  logic signed [31:0]            x_in,
  input  logic signed [31:0]            y_in,
  input  logic signed [31:0]            z_in,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic signed [31:0]            x_out,
  output logic signed [31:0]            y_out,
  output logic signed [31:0]            z_out,
  output logic                          on_axis,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ltilt_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ltilt_pkg::*;
  `include "assert_macros.svh"

  logic [30:0]        tilt_cosine;
  logic signed [31:0] tilt_sine;
  reg_idx_t           widx;

  sqrt_stage_t sq_chain [0:SQRT_CELLS];
  div_stage_t  dv_chain [0:DIV_CELLS];
  result_t     pipe_res, o_res, k_res;
  logic        en, pipe_v, take;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_cosine <= COS_RESET;
      tilt_sine   <= SIN_RESET;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_COSINE: tilt_cosine <= pwdata[30:0];
        REG_SINE:   tilt_sine   <= $signed(pwdata);
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_COSINE: prdata = {1'b0, tilt_cosine};
      REG_SINE:   prdata = tilt_sine;
      default:    prdata = '0;
    endcase
  end

  assign en = !k_res.valid;

  ltilt_front u_front (
    .clk(clk), .rst(rst), .en(en), .point_valid(point_valid),
    .x_in(x_in), .y_in(y_in), .z_in(z_in), .head(sq_chain[0])
  );

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    ltilt_sqrt_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .d(sq_chain[i]), .q(sq_chain[i+1])
    );
  end

  always_comb begin
    dv_chain[0].valid = sq_chain[SQRT_CELLS].valid;
    dv_chain[0].x     = sq_chain[SQRT_CELLS].x;
    dv_chain[0].y     = sq_chain[SQRT_CELLS].y;
    dv_chain[0].z     = sq_chain[SQRT_CELLS].z;
    dv_chain[0].sx    = sq_chain[SQRT_CELLS].sx;
    dv_chain[0].sy    = sq_chain[SQRT_CELLS].sy;
    dv_chain[0].r     = sq_chain[SQRT_CELLS].root;
    dv_chain[0].px    = {1'b0, sq_chain[SQRT_CELLS].mx[62:32]};
    dv_chain[0].lx    = sq_chain[SQRT_CELLS].mx[31:0];
    dv_chain[0].py    = {1'b0, sq_chain[SQRT_CELLS].my[62:32]};
    dv_chain[0].ly    = sq_chain[SQRT_CELLS].my[31:0];
  end

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    ltilt_div_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .d(dv_chain[j]), .q(dv_chain[j+1])
    );
  end

  ltilt_back u_back (
    .clk(clk), .rst(rst), .en(en), .d(dv_chain[DIV_CELLS]),
    .cosine(tilt_cosine), .sine(tilt_sine), .res(pipe_res)
  );

  assign pipe_v = pipe_res.valid && en;
  assign take   = o_res.valid && !result_stall;

  // skid empty here, so the pipe is running and its valid is pipe_v
  always_ff @(posedge clk) begin
    if (rst) begin
      o_res.valid <= 1'b0;
      k_res.valid <= 1'b0;
    end else if (k_res.valid) begin
      if (take) begin
        o_res       <= k_res;
        k_res.valid <= 1'b0;
      end
    end else if (!o_res.valid || take) begin
      o_res <= pipe_res;
    end else if (pipe_v) begin
      k_res <= pipe_res;
    end
  end

  assign point_stall  = k_res.valid;
  assign result_valid = o_res.valid;
  assign x_out        = o_res.x;
  assign y_out        = o_res.y;
  assign z_out        = o_res.z;
  assign on_axis      = o_res.on_axis;

  `ASSERT_SAME(a_skid_behind_out, k_res.valid, o_res.valid)
  `ASSERT_NEXT(a_skid_kept, k_res.valid && result_stall, k_res.valid)
  `ASSERT_SAME(a_axis_zero_xy, o_res.valid && o_res.on_axis, o_res.x == 0 && o_res.y == 0)

endmodule

@@ src/ltilt_front.sv @@
module ltilt_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     point_valid,
  input  logic signed [31:0]       x_in,
  input  logic signed [31:0]       y_in,
  input  logic signed [31:0]       z_in,
  output ltilt_pkg::sqrt_stage_t   head
);
  import ltilt_pkg::*;

  logic               a_valid;
  logic signed [31:0] ax, ay, az;
  logic signed [63:0] xx, yy, xz, yz;
  sqrt_stage_t        head_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= point_valid;
    end
    if (en) begin
      ax <= x_in;
      ay <= y_in;
      az <= z_in;
      xx <= x_in * x_in;
      yy <= y_in * y_in;
      xz <= x_in * z_in;
      yz <= y_in * z_in;
    end
  end

  always_comb begin
    head_next       = '0;
    head_next.valid = a_valid;
    head_next.x     = ax;
    head_next.y     = ay;
    head_next.z     = az;
    head_next.sx    = xz[63];
    head_next.sy    = yz[63];
    head_next.mx    = xz[63] ? 63'(-xz) : xz[62:0];
    head_next.my    = yz[63] ? 63'(-yz) : yz[62:0];
    head_next.n     = $unsigned(xx) + $unsigned(yy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head.valid <= 1'b0;
    end else if (en) begin
      head <= head_next;
    end
  end

endmodule

@@ src/ltilt_sqrt_cell.sv @@
module ltilt_sqrt_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  ltilt_pkg::sqrt_stage_t d,
  output ltilt_pkg::sqrt_stage_t q
);
  import ltilt_pkg::*;

  logic [35:0] rem_sh, trial;
  logic        ge;
  sqrt_stage_t q_next;

  always_comb begin
    rem_sh      = {d.rem, d.n[63:62]};
    trial       = {2'b00, d.root, 2'b01};
    ge          = rem_sh >= trial;
    q_next      = d;
    q_next.n    = {d.n[61:0], 2'b00};
    q_next.rem  = ge ? 34'(rem_sh - trial) : rem_sh[33:0];
    q_next.root = {d.root[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

@@ src/ltilt_div_cell.sv @@
module ltilt_div_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  ltilt_pkg::div_stage_t d,
  output ltilt_pkg::div_stage_t q
);
  import ltilt_pkg::*;

  logic [32:0] tx, ty, rz;
  logic        gx, gy;
  div_stage_t  q_next;

  always_comb begin
    rz        = {1'b0, d.r};
    tx        = {d.px, d.lx[31]};
    ty        = {d.py, d.ly[31]};
    gx        = tx >= rz;
    gy        = ty >= rz;
    q_next    = d;
    q_next.px = gx ? 32'(tx - rz) : tx[31:0];
    q_next.py = gy ? 32'(ty - rz) : ty[31:0];
    q_next.lx = {d.lx[30:0], gx};
    q_next.ly = {d.ly[30:0], gy};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end

endmodule

@@ src/ltilt_back.sv @@
module ltilt_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  ltilt_pkg::div_stage_t d,
  input  logic [30:0]           cosine,
  input  logic signed [31:0]    sine,
  output ltilt_pkg::result_t    res
);
  import ltilt_pkg::*;

  function automatic logic [31:0] round_sat(input logic signed [63:0] a,
                                             input logic signed [64:0] b,
                                             input logic sub);
    logic signed [66:0] s;
    logic signed [36:0] v;
    s = sub ? (a - b + HALF_Q30) : (a + b + HALF_Q30);
    v = s[66:30];
    if (v > SAT_MAX) begin
      round_sat = SAT_MAX[31:0];
    end else if (v < SAT_MIN) begin
      round_sat = SAT_MIN[31:0];
    end else begin
      round_sat = v[31:0];
    end
  endfunction

  // stage C: signed quotients
  logic               c_valid, c_axis;
  logic signed [31:0] c_x, c_y, c_z;
  logic signed [32:0] c_ux, c_uy, c_r;
  // stage D: products
  logic               p_valid, p_axis;
  logic signed [63:0] p_cx, p_cy, p_cz;
  logic signed [64:0] p_sx, p_sy, p_sr;
  result_t            res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      p_valid <= 1'b0;
    end else if (en) begin
      c_valid <= d.valid;
      p_valid <= c_valid;
    end
    if (en) begin
      c_axis <= d.r == '0;
      c_x    <= d.x;
      c_y    <= d.y;
      c_z    <= d.z;
      c_r    <= $signed({1'b0, d.r});
      if (d.r == '0) begin
        c_ux <= '0;
        c_uy <= '0;
      end else begin
        c_ux <= d.sx ? -$signed({1'b0, d.lx}) : $signed({1'b0, d.lx});
        c_uy <= d.sy ? -$signed({1'b0, d.ly}) : $signed({1'b0, d.ly});
      end
      p_axis <= c_axis;
      p_cx   <= $signed({1'b0, cosine}) * c_x;
      p_cy   <= $signed({1'b0, cosine}) * c_y;
      p_cz   <= $signed({1'b0, cosine}) * c_z;
      p_sx   <= sine * c_ux;
      p_sy   <= sine * c_uy;
      p_sr   <= sine * c_r;
    end
  end

  always_comb begin
    res_next.valid   = p_valid;
    res_next.on_axis = p_axis;
    res_next.x       = round_sat(p_cx, p_sx, 1'b1);
    res_next.y       = round_sat(p_cy, p_sy, 1'b1);
    res_next.z       = round_sat(p_cz, p_sr, 1'b0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res <= res_next;
    end
  end

endmodule

@@ tb/tb_lidar_point_elevation_tilt_core.sv @@
module tb_lidar_point_elevation_tilt_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ltilt_pkg::*;

  localparam int LATENCY = 69;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               axis;
  } tilted_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic point_valid = 1'b0;
  logic point_stall;
  logic signed [31:0] x_in = '0, y_in = '0, z_in = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [31:0] x_out, y_out, z_out;
  logic on_axis;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lidar_point_elevation_tilt_core u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [30:0] cos_q30;
  logic signed [31:0] sin_q30;
  tilted_t tilted_q[$];
  int errors = 0;
  int points_sent = 0;
  int results_seen = 0;
  int axis_seen = 0;
  longint cycles = 0;
  bit idle_sender = 1'b1;
  bit idle_receiver = 1'b1;

  function automatic logic [31:0] root64(logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem = n;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root[31:0];
  endfunction

  function automatic logic signed [31:0] round_sat(logic signed [127:0] acc);
    logic signed [127:0] v;
    v = (acc + 128'sd536870912) >>> 30;
    if (v > 128'sd2147483647) return 32'h7fffffff;
    if (v < -128'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic tilted_t tilt_point(logic signed [31:0] x, logic signed [31:0] y,
                                         logic signed [31:0] z);
    tilted_t t;
    logic signed [127:0] xs, ys, zs, r, ux, uy, c, s;
    logic [63:0] sq;
    xs = x; ys = y; zs = z;
    sq = 64'(xs * xs) + 64'(ys * ys);
    r = {96'd0, root64(sq)};
    ux = 0; uy = 0;
    if (r != 0) begin
      ux = (xs * zs) / r;
      uy = (ys * zs) / r;
    end
    c = {97'd0, cos_q30};
    s = sin_q30;
    t.x = round_sat(c * xs - s * ux);
    t.y = round_sat(c * ys - s * uy);
    t.z = round_sat(c * zs + s * r);
    t.axis = (r == 0);
    return t;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) result_stall <= idle_receiver ? ($urandom_range(99) < 35) : 1'b0;
  end

  always @(posedge clk) begin
    tilted_t want;
    if (!rst && result_valid && !result_stall) begin
      if (tilted_q.size() == 0) begin
        report_mismatch("unexpected x_out", x_out, 32'd0);
      end else begin
        want = tilted_q.pop_front();
        if (x_out !== want.x) report_mismatch("x_out", x_out, want.x);
        if (y_out !== want.y) report_mismatch("y_out", y_out, want.y);
        if (z_out !== want.z) report_mismatch("z_out", z_out, want.z);
        if (on_axis !== want.axis) report_mismatch("on_axis", 32'(on_axis), 32'(want.axis));
        if (want.axis) axis_seen++;
      end
      results_seen++;
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(idx)); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_COSINE) cos_q30 = value[30:0];
    else sin_q30 = value;
  endtask

  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z);
    while (idle_sender && $urandom_range(99) < 35) begin
      point_valid <= 1'b0;
      @(posedge clk);
    end
    point_valid <= 1'b1;
    x_in <= x; y_in <= y; z_in <= z;
    tilted_q.push_back(tilt_point(x, y, z));
    do @(posedge clk); while (point_stall);
    points_sent++;
  endtask

  task automatic drain();
    point_valid <= 1'b0;
    while (tilted_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(65535) - 32768;
      2: return {{16{1'b0}}, 16'($urandom)} << $urandom_range(15);
      3: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
                                  : 32'h80000000 + $urandom_range(3);
      default: return 32'($signed($urandom_range(200000)) - 100000) <<< 4;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] ext[6];
    ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'hffffffff, 32'h00010000};
    send_point(0, 0, 0);
    send_point(0, 0, 32'h7fffffff);
    send_point(0, 0, 32'h80000000);
    send_point(32'h00010000, 0, 32'h00010000);
    send_point(0, 32'hffff0000, 32'h00030000);
    send_point(32'h80000000, 32'h80000000, 32'h80000000);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_point(32'h80000000, 32'h7fffffff, 32'h80000000);
    send_point(1, 0, 32'h80000000);
    send_point(0, 1, 32'h7fffffff);
    for (int i = 0; i < 6; i++) send_point(ext[i], ext[5 - i], ext[(i + 2) % 6]);
  endtask

  task automatic test_random(int count);
    logic [31:0] x, y;
    for (int i = 0; i < count; i++) begin
      x = rand_coord();
      y = rand_coord();
      if ($urandom_range(19) == 0) begin x = 0; y = 0; end
      send_point(x, y, rand_coord());
    end
  endtask

  task automatic test_settings();
    write_reg(REG_COSINE, 32'd1073741824);
    write_reg(REG_SINE, -32'sd1073741824);
    test_directed();
    test_random(60);
    drain();
    write_reg(REG_COSINE, 32'd0);
    write_reg(REG_SINE, 32'sd1073741824);
    test_random(60);
    drain();
    write_reg(REG_COSINE, 32'hffffffff);
    write_reg(REG_SINE, 32'h80000000);
    test_random(50);
    drain();
    write_reg(REG_COSINE, 32'h7fffffff);
    write_reg(REG_SINE, 32'h7fffffff);
    test_random(50);
    drain();
    write_reg(REG_COSINE, $urandom);
    write_reg(REG_SINE, $urandom);
    test_random(60);
    drain();
  endtask

  initial begin
    cos_q30 = COS_RESET;
    sin_q30 = SIN_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(130);
    drain();
    idle_sender = 1'b0;
    idle_receiver = 1'b0;
    test_random(100);
    idle_sender = 1'b1;
    idle_receiver = 1'b1;
    drain();
    test_settings();
    drain();
    $display("sent %0d points over six tilt settings incl. extremes and raw register values;",
             points_sent);
    $display("checked %0d results, %0d of them on the vertical axis", results_seen, axis_seen);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
